// File: sv/affine_transform_accumulator_core_macros.svh
// ============================================================================
// affine_transform_accumulator_core_macros
// Assertion macros shared by the affine transform accumulator.
// ============================================================================
// Each macro expects i_clk and i_rst_n to be visible where it is used.
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_CORE_MACROS_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ATAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ATAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/atac_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// atac_pkg
// Types, constants and the CORDIC arctangent table of the affine transform
// accumulator.
// ============================================================================
package atac_pkg;

    localparam int FRAC_BITS_DEF  = 16;
    localparam int ANGLE_BITS_DEF = 16;

    localparam int DATA_W      = 32;
    localparam int ANGLE_W     = 16;
    localparam int CMD_W       = 2;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 192;

    localparam int CORDIC_STAGES = 28;
    localparam int CORDIC_FRAC   = 30;
    localparam int CORDIC_W      = 34;
    localparam int ITER_W        = 5;
    localparam logic signed [CORDIC_W-1:0] CORDIC_START = 34'sd652032874;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_IDENT = 2'd0,
        CMD_TRANS = 2'd1,
        CMD_SCALE = 2'd2,
        CMD_ROT   = 2'd3
    } t_cmd;

    // One classified command as it travels from front to back.
    typedef struct packed {
        t_cmd                     cmd;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] c;
        logic signed [DATA_W-1:0] s;
    } t_op;

    typedef enum logic [1:0] {
        F_IDLE,
        F_ITER,
        F_RND,
        F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE,
        B_TRANS,
        B_MUL0,
        B_MUL1,
        B_SUM,
        B_RND,
        B_DONE
    } t_bstate;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic signed [CORDIC_W-1:0] atan_turn(input logic [ITER_W-1:0] idx);
        logic signed [CORDIC_W-1:0] v;
        case (idx)
            5'd0:    v = 34'sd536870912;
            5'd1:    v = 34'sd316933406;
            5'd2:    v = 34'sd167458907;
            5'd3:    v = 34'sd85004756;
            5'd4:    v = 34'sd42667331;
            5'd5:    v = 34'sd21354465;
            5'd6:    v = 34'sd10679838;
            5'd7:    v = 34'sd5340245;
            5'd8:    v = 34'sd2670163;
            5'd9:    v = 34'sd1335087;
            5'd10:   v = 34'sd667544;
            5'd11:   v = 34'sd333772;
            5'd12:   v = 34'sd166886;
            5'd13:   v = 34'sd83443;
            5'd14:   v = 34'sd41722;
            5'd15:   v = 34'sd20861;
            5'd16:   v = 34'sd10430;
            5'd17:   v = 34'sd5215;
            5'd18:   v = 34'sd2608;
            5'd19:   v = 34'sd1304;
            5'd20:   v = 34'sd652;
            5'd21:   v = 34'sd326;
            5'd22:   v = 34'sd163;
            5'd23:   v = 34'sd81;
            5'd24:   v = 34'sd41;
            5'd25:   v = 34'sd20;
            5'd26:   v = 34'sd10;
            5'd27:   v = 34'sd5;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// File: sv/atac_front.sv
`timescale 1ns / 1ps
// ============================================================================
// atac_front
// Accepts commands, runs the CORDIC for rotations and pushes classified
// operations with their cosine and sine into the queue.
// ============================================================================
module atac_front #(
    parameter int FRAC_BITS  = atac_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = atac_pkg::ANGLE_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [atac_pkg::IN_TDATA_W-1:0]     i_data,
    output logic                                o_push,
    output atac_pkg::t_op                       o_push_data,
    input  logic                                i_push_ready
);

    localparam int DROP = atac_pkg::CORDIC_FRAC - FRAC_BITS;
    localparam int ASH  = atac_pkg::DATA_W - ANGLE_BITS;
    localparam logic [31:0] ANG_MASK = 32'((64'd1 << ANGLE_BITS) - 64'd1);
    localparam logic signed [atac_pkg::CORDIC_W-1:0] C_HALF = 34'sd1 <<< (DROP - 1);

    atac_pkg::t_fstate                         r_fstate, n_fstate;
    logic [atac_pkg::ITER_W-1:0]               r_iter, n_iter;
    logic signed [atac_pkg::CORDIC_W-1:0]      r_x, n_x, r_y, n_y, r_z, n_z;
    logic [1:0]                                r_q, n_q;
    logic signed [atac_pkg::DATA_W-1:0]        r_px, n_px, r_py, n_py;
    logic signed [atac_pkg::DATA_W-1:0]        r_cr, n_cr, r_sr, n_sr;

    atac_pkg::t_cmd                            w_cmd;
    logic signed [atac_pkg::DATA_W-1:0]        w_px, w_py;
    logic [atac_pkg::ANGLE_W-1:0]              w_angle;
    logic [31:0]                               w_phase, w_qsum, w_rem;
    logic [1:0]                                w_quad;
    logic signed [atac_pkg::CORDIC_W-1:0]      w_sx, w_sy, w_at, w_xr, w_yr;
    logic signed [atac_pkg::DATA_W-1:0]        w_c, w_s;
    logic                                      w_accept;

    function automatic logic signed [atac_pkg::CORDIC_W-1:0] atan_lookup(
        input logic [atac_pkg::ITER_W-1:0] idx
    );
        return atac_pkg::atan_turn(idx);
    endfunction

    assign w_cmd   = atac_pkg::t_cmd'(i_data[1:0]);
    assign w_px    = i_data[33:2];
    assign w_py    = i_data[65:34];
    assign w_angle = i_data[81:66];

    // Scale the angle to a 32-bit phase and split off the nearest quarter turn.
    assign w_phase = (32'(w_angle) & ANG_MASK) << ASH;
    assign w_qsum  = w_phase + 32'h2000_0000;
    assign w_quad  = w_qsum[31:30];
    assign w_rem   = {w_phase[31:30] - w_quad, w_phase[29:0]};

    assign w_sx = r_x >>> r_iter;
    assign w_sy = r_y >>> r_iter;
    assign w_at = atan_lookup(r_iter);
    assign w_xr = (r_x + C_HALF) >>> DROP;
    assign w_yr = (r_y + C_HALF) >>> DROP;

    always_comb begin
        case (r_q)
            2'd0: begin
                w_c = r_cr;
                w_s = r_sr;
            end
            2'd1: begin
                w_c = -r_sr;
                w_s = r_cr;
            end
            2'd2: begin
                w_c = -r_cr;
                w_s = -r_sr;
            end
            default: begin
                w_c = r_sr;
                w_s = -r_cr;
            end
        endcase
    end

    assign o_ready  = (r_fstate == atac_pkg::F_IDLE) && i_push_ready;
    assign w_accept = i_valid && o_ready;

    always_comb begin
        n_fstate = r_fstate;
        n_iter   = r_iter;
        n_x      = r_x;
        n_y      = r_y;
        n_z      = r_z;
        n_q      = r_q;
        n_px     = r_px;
        n_py     = r_py;
        n_cr     = r_cr;
        n_sr     = r_sr;
        o_push   = 1'b0;
        o_push_data.cmd = w_cmd;
        o_push_data.px  = w_px;
        o_push_data.py  = w_py;
        o_push_data.c   = '0;
        o_push_data.s   = '0;
        case (r_fstate)
            atac_pkg::F_IDLE: begin
                if (w_accept) begin
                    if (w_cmd == atac_pkg::CMD_ROT) begin
                        n_fstate = atac_pkg::F_ITER;
                        n_iter   = '0;
                        n_x      = atac_pkg::CORDIC_START;
                        n_y      = '0;
                        n_z      = 34'($signed(w_rem));
                        n_q      = w_quad;
                        n_px     = w_px;
                        n_py     = w_py;
                    end else begin
                        o_push = 1'b1;
                    end
                end
            end
            atac_pkg::F_ITER: begin
                if (!r_z[atac_pkg::CORDIC_W-1]) begin
                    n_x = r_x - w_sy;
                    n_y = r_y + w_sx;
                    n_z = r_z - w_at;
                end else begin
                    n_x = r_x + w_sy;
                    n_y = r_y - w_sx;
                    n_z = r_z + w_at;
                end
                n_iter = r_iter + 5'd1;
                if (r_iter == 5'(atac_pkg::CORDIC_STAGES - 1)) begin
                    n_fstate = atac_pkg::F_RND;
                end
            end
            atac_pkg::F_RND: begin
                n_cr     = w_xr[atac_pkg::DATA_W-1:0];
                n_sr     = w_yr[atac_pkg::DATA_W-1:0];
                n_fstate = atac_pkg::F_PUSH;
            end
            atac_pkg::F_PUSH: begin
                o_push_data.cmd = atac_pkg::CMD_ROT;
                o_push_data.px  = r_px;
                o_push_data.py  = r_py;
                o_push_data.c   = w_c;
                o_push_data.s   = w_s;
                if (i_push_ready) begin
                    o_push   = 1'b1;
                    n_fstate = atac_pkg::F_IDLE;
                end
            end
            default: begin
                n_fstate = atac_pkg::F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fstate <= atac_pkg::F_IDLE;
        end else begin
            r_fstate <= n_fstate;
        end
    end

    always_ff @(posedge i_clk) begin
        r_iter <= n_iter;
        r_x    <= n_x;
        r_y    <= n_y;
        r_z    <= n_z;
        r_q    <= n_q;
        r_px   <= n_px;
        r_py   <= n_py;
        r_cr   <= n_cr;
        r_sr   <= n_sr;
    end

endmodule

// File: sv/atac_fifo.sv
`timescale 1ns / 1ps
// ============================================================================
// atac_fifo
// Short register queue of classified operations between front and back.
// ============================================================================
module atac_fifo #(
    parameter int DEPTH = atac_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  atac_pkg::t_op i_push_data,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output atac_pkg::t_op o_pop_data,
    input  logic          i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    atac_pkg::t_op   r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr, r_rptr, n_rptr;
    logic [CW-1:0]   r_count, n_count;
    logic            w_do_push, w_do_pop;

    assign o_push_ready = (r_count != CW'(DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rptr];
    assign w_do_push    = i_push && o_push_ready;
    assign w_do_pop     = i_pop && o_pop_valid;

    always_comb begin
        n_wptr  = r_wptr;
        n_rptr  = r_rptr;
        n_count = r_count;
        if (w_do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + AW'(1);
        end
        if (w_do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + AW'(1);
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + CW'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wptr] <= i_push_data;
        end
    end

endmodule

// File: sv/atac_back.sv
`timescale 1ns / 1ps
// ============================================================================
// atac_back
// Holds the transform and applies one queued operation at a time, for scale and
// rotate one column per pass on two shared multipliers, then loads the result beat.
// ============================================================================
module atac_back #(
    parameter int FRAC_BITS = atac_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_q_valid,
    input  atac_pkg::t_op                      i_q_data,
    output logic                               o_q_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [atac_pkg::OUT_TDATA_W-1:0]   o_data
);

    localparam int DW = atac_pkg::DATA_W;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 1;
    localparam int RW = PW + 2;
    localparam logic signed [DW-1:0] ONE      = DW'(64'd1 << FRAC_BITS);
    localparam logic signed [RW-1:0] RND_HALF = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [RW-1:0] SAT_MAX  = 66'sd2147483647;
    localparam logic signed [RW-1:0] SAT_MIN  = -66'sd2147483648;
    localparam logic [1:0]           LAST_COL = 2'd2;

    atac_pkg::t_bstate         r_bstate, n_bstate;
    logic [1:0]                r_col, n_col;
    logic signed [DW-1:0]      r_m00, r_m01, r_m02, r_m10, r_m11, r_m12;
    logic signed [DW-1:0]      n_m00, n_m01, n_m02, n_m10, n_m11, n_m12;
    atac_pkg::t_op             r_op, n_op;
    logic signed [PW-1:0]      r_pa0, n_pa0, r_pb0, n_pb0, r_pa1, n_pa1, r_pb1, n_pb1;
    logic signed [SW-1:0]      r_sa, n_sa, r_sb, n_sb;
    logic                      r_out_valid, n_out_valid;
    logic [atac_pkg::OUT_TDATA_W-1:0] r_out_data, n_out_data;

    logic                      w_is_scale;
    logic signed [DW-1:0]      w_ca, w_ma, w_cb, w_mb;
    logic signed [PW-1:0]      w_prod_a, w_prod_b;
    logic                      w_out_free;

    function automatic logic signed [DW-1:0] round_sat(input logic signed [SW-1:0] v);
        logic signed [RW-1:0] t;
        t = (RW'(v) + RND_HALF) >>> FRAC_BITS;
        if (t > SAT_MAX) begin
            return 32'sh7FFF_FFFF;
        end else if (t < SAT_MIN) begin
            return 32'sh8000_0000;
        end
        return t[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] add_sat(
        input logic signed [DW-1:0] a,
        input logic signed [DW-1:0] b
    );
        logic signed [DW:0] t;
        t = (DW+1)'(a) + (DW+1)'(b);
        if (t[DW] != t[DW-1]) begin
            return t[DW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end
        return t[DW-1:0];
    endfunction

    assign w_is_scale = (r_op.cmd == atac_pkg::CMD_SCALE);

    // Operand selection: pass one takes row 0 (row 1 for scale's b), pass two row 1.
    always_comb begin
        if (r_bstate == atac_pkg::B_MUL1) begin
            w_ca = w_is_scale ? '0 : r_op.s;
            w_ma = r_m10;
            w_cb = w_is_scale ? '0 : r_op.c;
            w_mb = r_m10;
        end else begin
            w_ca = w_is_scale ? r_op.px : r_op.c;
            w_ma = r_m00;
            w_cb = w_is_scale ? r_op.py : r_op.s;
            w_mb = w_is_scale ? r_m10 : r_m00;
        end
    end

    assign w_prod_a = PW'(w_ca) * PW'(w_ma);
    assign w_prod_b = PW'(w_cb) * PW'(w_mb);

    assign w_out_free = !r_out_valid || i_ready;
    assign o_valid    = r_out_valid;
    assign o_data     = r_out_data;

    always_comb begin
        n_bstate    = r_bstate;
        n_col       = r_col;
        n_m00       = r_m00;
        n_m01       = r_m01;
        n_m02       = r_m02;
        n_m10       = r_m10;
        n_m11       = r_m11;
        n_m12       = r_m12;
        n_op        = r_op;
        n_pa0       = r_pa0;
        n_pb0       = r_pb0;
        n_pa1       = r_pa1;
        n_pb1       = r_pb1;
        n_sa        = r_sa;
        n_sb        = r_sb;
        n_out_valid = r_out_valid && !i_ready;
        n_out_data  = r_out_data;
        o_q_pop     = 1'b0;
        case (r_bstate)
            atac_pkg::B_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_op    = i_q_data;
                    n_col   = '0;
                    case (i_q_data.cmd)
                        atac_pkg::CMD_IDENT: begin
                            n_m00    = ONE;
                            n_m01    = '0;
                            n_m02    = '0;
                            n_m10    = '0;
                            n_m11    = ONE;
                            n_m12    = '0;
                            n_bstate = atac_pkg::B_DONE;
                        end
                        atac_pkg::CMD_TRANS: begin
                            n_bstate = atac_pkg::B_TRANS;
                        end
                        default: begin
                            n_bstate = atac_pkg::B_MUL0;
                        end
                    endcase
                end
            end
            atac_pkg::B_TRANS: begin
                n_m02    = add_sat(r_m02, r_op.px);
                n_m12    = add_sat(r_m12, r_op.py);
                n_bstate = atac_pkg::B_DONE;
            end
            atac_pkg::B_MUL0: begin
                n_pa0    = w_prod_a;
                n_pb0    = w_prod_b;
                n_bstate = atac_pkg::B_MUL1;
            end
            atac_pkg::B_MUL1: begin
                n_pa1    = w_prod_a;
                n_pb1    = w_prod_b;
                n_bstate = atac_pkg::B_SUM;
            end
            atac_pkg::B_SUM: begin
                n_sa     = SW'(r_pa0) - SW'(r_pa1);
                n_sb     = SW'(r_pb0) + SW'(r_pb1);
                n_bstate = atac_pkg::B_RND;
            end
            atac_pkg::B_RND: begin
                // Rows rotate left so the next column always sits at column 0.
                n_m00 = r_m01;
                n_m01 = r_m02;
                n_m02 = round_sat(r_sa);
                n_m10 = r_m11;
                n_m11 = r_m12;
                n_m12 = round_sat(r_sb);
                n_col = r_col + 2'd1;
                n_bstate = (r_col == LAST_COL) ? atac_pkg::B_DONE : atac_pkg::B_MUL0;
            end
            atac_pkg::B_DONE: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_m12, r_m11, r_m10, r_m02, r_m01, r_m00};
                    n_bstate    = atac_pkg::B_IDLE;
                end
            end
            default: begin
                n_bstate = atac_pkg::B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bstate    <= atac_pkg::B_IDLE;
            r_col       <= '0;
            r_out_valid <= 1'b0;
            r_m00       <= ONE;
            r_m01       <= '0;
            r_m02       <= '0;
            r_m10       <= '0;
            r_m11       <= ONE;
            r_m12       <= '0;
        end else begin
            r_bstate    <= n_bstate;
            r_col       <= n_col;
            r_out_valid <= n_out_valid;
            r_m00       <= n_m00;
            r_m01       <= n_m01;
            r_m02       <= n_m02;
            r_m10       <= n_m10;
            r_m11       <= n_m11;
            r_m12       <= n_m12;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_pa0      <= n_pa0;
        r_pb0      <= n_pb0;
        r_pa1      <= n_pa1;
        r_pb1      <= n_pb1;
        r_sa       <= n_sa;
        r_sb       <= n_sb;
        r_out_data <= n_out_data;
    end

endmodule

// File: sv/affine_transform_accumulator_core.sv
`timescale 1ns / 1ps
// ============================================================================
// affine_transform_accumulator_core
// Accumulates a 2D affine transform from identity, translate, scale and
// rotate commands and returns the six updated entries after each command.
// ============================================================================
//  channel   direction  beat contents
//  s_axis    in         command: cmd, param_x, param_y, angle
//  m_axis    out        transform: m00, m01, m02, m10, m11, m12
//
// Non-rotate commands enter the queue in the cycle they are accepted; a rotate
// holds the front while the 28-step CORDIC loop and rounding run.
// The back loads identity directly and adds a translate in a single state; scale
// or rotate runs MUL0, MUL1, SUM and RND per column on the two shared multipliers.
// A stalled output holds the back; the queue lets the front keep accepting until it fills.
// No clearing pass is needed after reset; the transform resets to identity.
module affine_transform_accumulator_core #(
    parameter int FRAC_BITS  = atac_pkg::FRAC_BITS_DEF,
    parameter int ANGLE_BITS = atac_pkg::ANGLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // cmd[1:0], param_x[33:2], param_y[65:34], angle[81:66], zero[87:82]
    input  logic [atac_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // m00[31:0], m01[63:32], m02[95:64], m10[127:96], m11[159:128], m12[191:160]
    output logic [atac_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);

    logic          w_q_push, w_q_push_ready, w_q_valid, w_q_pop;
    atac_pkg::t_op w_q_in, w_q_out;
    logic          w_in_accept, w_in_rot;

    assign w_in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign w_in_rot    = (atac_pkg::t_cmd'(i_s_axis_tdata[1:0]) == atac_pkg::CMD_ROT);

    atac_front #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .o_push       (w_q_push),
        .o_push_data  (w_q_in),
        .i_push_ready (w_q_push_ready)
    );

    atac_fifo #(
        .DEPTH (atac_pkg::QUEUE_DEPTH)
    ) u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_q_push),
        .i_push_data  (w_q_in),
        .o_push_ready (w_q_push_ready),
        .o_pop_valid  (w_q_valid),
        .o_pop_data   (w_q_out),
        .i_pop        (w_q_pop)
    );

    atac_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_q_data  (w_q_out),
        .o_q_pop   (w_q_pop),
        .o_valid   (o_m_axis_tvalid),
        .i_ready   (i_m_axis_tready),
        .o_data    (o_m_axis_tdata)
    );

`include "affine_transform_accumulator_core_macros.svh"

    `ATAC_ASSERT_IMP(a_push_has_room, w_q_push, w_q_push_ready, "queue pushed while full")
    `ATAC_ASSERT_IMP(a_pop_has_data, w_q_pop, w_q_valid, "queue popped while empty")
    `ATAC_ASSERT_IMP(a_plain_cmd_queued, w_in_accept && !w_in_rot, w_q_push, "command not queued")
    `ATAC_ASSERT_NEXT(a_rotate_busy, w_in_accept && w_in_rot, !o_s_axis_tready, "beat in CORDIC")

endmodule
